// File: rtl/smn_pkg.sv
package smn_pkg;

	// Short name shape
	localparam int BASE_CHARS = 5;
	localparam int EXT_CHARS  = 3;
	localparam int MAX_UNITS  = BASE_CHARS + 4 + EXT_CHARS;

	localparam int BC_W  = $clog2(BASE_CHARS + 1);
	localparam int EC_W  = $clog2(EXT_CHARS + 1);
	localparam int N_W   = $clog2(MAX_UNITS + 1);
	localparam int POS_W = $clog2(MAX_UNITS);

	// Check-digit arithmetic: sum kept mod 42*42, split in base 42
	localparam int SYMS      = 42;
	localparam int SUM_MOD   = SYMS * SYMS;
	localparam int SUM_W     = 11;
	localparam int DIGIT_W   = 6;
	localparam int RECIP     = 1561;  // ceil(2^16 / 42), exact for sums below 1764
	localparam int RECIP_SH  = 16;
	localparam int RECIP_W   = 11;

	// Queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int QP_W    = $clog2(Q_DEPTH);
	localparam int QC_W    = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	// One finished name, as handed from front to back
	typedef struct packed {
		logic [BASE_CHARS-1:0][7:0] base;
		logic [BC_W-1:0]            base_cnt;
		logic [EXT_CHARS-1:0][7:0]  ext;
		logic [EC_W-1:0]            ext_cnt;
		logic                       lead_dot;
		logic [SUM_W-1:0]           sum;
	} desc_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

	// ASCII upper-case, other bytes pass through
	function automatic logic [7:0] upcase(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= 8'h61 && b <= 8'h7A) begin
			r = b - 8'h20;
		end
		return r;
	endfunction

	// Map a base-42 digit to its symbol
	function automatic logic [7:0] sym_char(input logic [DIGIT_W-1:0] d);
		logic [7:0] r;
		r = 8'h30;
		case (d)
			6'd36:   r = 8'h5F;  // '_'
			6'd37:   r = 8'h2D;  // '-'
			6'd38:   r = 8'h21;  // '!'
			6'd39:   r = 8'h40;  // '@'
			6'd40:   r = 8'h23;  // '#'
			6'd41:   r = 8'h24;  // '$'
			default: begin
				if (d < 6'd10) begin
					r = 8'h30 + {2'b00, d};
				end else if (d < 6'd36) begin
					r = 8'h41 + {2'b00, d} - 8'd10;
				end
			end
		endcase
		return r;
	endfunction

endpackage

// File: rtl/smn_front.sv
module smn_front
	import smn_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] name_byte,
	input  logic       last_byte,
	output logic       push,
	output desc_t      push_desc
);

	localparam logic [BC_W-1:0]  BC_MAX = BC_W'(BASE_CHARS);
	localparam logic [EC_W-1:0]  EC_MAX = EC_W'(EXT_CHARS);
	localparam logic [SUM_W:0]   MODV   = (SUM_W+1)'(SUM_MOD);

	logic                       at_start_q;
	logic                       lead_q;
	logic [BASE_CHARS-1:0][7:0] base_q;
	logic [BC_W-1:0]            bc_q;
	logic [EXT_CHARS-1:0][7:0]  ext_q;
	logic [EC_W-1:0]            ec_q;
	logic                       dot_q;
	logic [SUM_W-1:0]           sum_q;

	logic                       is_dot;
	logic [7:0]                 up;
	logic [SUM_W:0]             sum_add;
	logic [SUM_W-1:0]           sum_nx;
	logic                       lead_nx;
	logic [BASE_CHARS-1:0][7:0] base_nx;
	logic [BC_W-1:0]            bc_nx;
	logic [EXT_CHARS-1:0][7:0]  ext_nx;
	logic [EC_W-1:0]            ec_nx;
	logic                       dot_nx;

	// Fold the current byte into the run
	always_comb begin
		is_dot  = (name_byte == CH_DOT);
		up      = upcase(name_byte);
		lead_nx = lead_q | (at_start_q & is_dot);
		sum_add = {1'b0, sum_q} + {{(SUM_W-7){1'b0}}, name_byte};
		sum_nx  = (sum_add >= MODV) ? SUM_W'(sum_add - MODV) : sum_add[SUM_W-1:0];
		base_nx = base_q;
		bc_nx   = bc_q;
		ext_nx  = ext_q;
		ec_nx   = ec_q;
		dot_nx  = dot_q;
		if (is_dot) begin
			dot_nx = 1'b1;
			ec_nx  = '0;
		end else begin
			if (bc_q < BC_MAX) begin
				for (int i = 0; i < BASE_CHARS; i++) begin
					if (bc_q == BC_W'(i)) begin
						base_nx[i] = up;
					end
				end
				bc_nx = bc_q + 1'b1;
			end
			if (dot_q && ec_q < EC_MAX) begin
				for (int i = 0; i < EXT_CHARS; i++) begin
					if (ec_q == EC_W'(i)) begin
						ext_nx[i] = up;
					end
				end
				ec_nx = ec_q + 1'b1;
			end
		end
	end

	// Hand the finished name to the queue
	assign push                = accept & last_byte;
	assign push_desc.base      = base_nx;
	assign push_desc.base_cnt  = bc_nx;
	assign push_desc.ext       = ext_nx;
	assign push_desc.ext_cnt   = ec_nx;
	assign push_desc.lead_dot  = lead_nx;
	assign push_desc.sum       = sum_nx;

	// Run control state; clear it at the end of each name
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			lead_q     <= 1'b0;
			bc_q       <= '0;
			ec_q       <= '0;
			dot_q      <= 1'b0;
			sum_q      <= '0;
		end else if (accept) begin
			if (last_byte) begin
				at_start_q <= 1'b1;
				lead_q     <= 1'b0;
				bc_q       <= '0;
				ec_q       <= '0;
				dot_q      <= 1'b0;
				sum_q      <= '0;
			end else begin
				at_start_q <= 1'b0;
				lead_q     <= lead_nx;
				bc_q       <= bc_nx;
				ec_q       <= ec_nx;
				dot_q      <= dot_nx;
				sum_q      <= sum_nx;
			end
		end
	end

	// Character stores hold no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= base_nx;
			ext_q  <= ext_nx;
		end
	end

endmodule

// File: rtl/smn_queue.sv
module smn_queue
	import smn_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  desc_t   push_desc,
	input  logic    pop,
	output desc_t   head,
	output q_stat_t stat
);

	localparam logic [QP_W-1:0] PTR_LAST = QP_W'(Q_DEPTH - 1);
	localparam logic [QC_W-1:0] CNT_FULL = QC_W'(Q_DEPTH);

	desc_t           mem_q [Q_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] cnt_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.valid = (cnt_q != '0);
	assign stat.full  = (cnt_q == CNT_FULL);

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/smn_back.sv
module smn_back
	import smn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  desc_t       head,
	input  q_stat_t     q_stat,
	output logic        pop,
	output logic        unit_valid,
	input  logic        unit_ready,
	output logic [15:0] code_unit,
	output logic        last_unit,
	output logic        no_short_name,
	output logic [4:0]  name_bytes
);

	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
	localparam int                 PROD_W  = SUM_W + RECIP_W;

	logic               cur_valid_q;
	desc_t              cur_q;
	logic [POS_W-1:0]   pos_q;
	logic [DIGIT_W-1:0] hi_q;

	logic               out_valid_q;
	logic [7:0]         code_q;
	logic               last_q;
	logic               nsn_q;
	logic [4:0]         nb_q;

	logic [PROD_W-1:0]  hi_prod;
	logic [SUM_W-1:0]   hi_x42;
	logic [SUM_W-1:0]   lo_full;
	logic [DIGIT_W-1:0] lo;
	logic [N_W-1:0]     n_tot;
	logic [N_W-1:0]     p;
	logic [N_W-1:0]     bc;
	logic [N_W-1:0]     off;
	logic               is_last;
	logic               emit;
	logic [7:0]         ch;

	// High check digit by reciprocal multiply of the queued sum
	assign hi_prod = PROD_W'(head.sum) * PROD_W'(RECIP_C);

	// Low check digit from the registered high digit: sum - 42*hi
	assign hi_x42  = SUM_W'({hi_q, 5'b0}) + SUM_W'({hi_q, 3'b0}) + SUM_W'({hi_q, 1'b0});
	assign lo_full = cur_q.sum - hi_x42;
	assign lo      = lo_full[DIGIT_W-1:0];

	// Unit count and position of the current name
	always_comb begin
		bc    = N_W'(cur_q.base_cnt);
		p     = N_W'(pos_q);
		off   = p - bc - N_W'(4);
		n_tot = cur_q.lead_dot ? N_W'(1) : bc + N_W'(4) + N_W'(cur_q.ext_cnt);
		is_last = (p + N_W'(1) == n_tot);
	end

	// Pick the character at the current position
	always_comb begin
		ch = 8'h00;
		if (cur_q.lead_dot) begin
			ch = 8'h00;
		end else if (p < bc) begin
			for (int i = 0; i < BASE_CHARS; i++) begin
				if (p == N_W'(i)) begin
					ch = cur_q.base[i];
				end
			end
		end else if (p == bc) begin
			ch = CH_TILDE;
		end else if (p == bc + N_W'(1)) begin
			ch = sym_char(hi_q);
		end else if (p == bc + N_W'(2)) begin
			ch = sym_char(lo);
		end else if (p == bc + N_W'(3)) begin
			ch = CH_DOT;
		end else begin
			for (int i = 0; i < EXT_CHARS; i++) begin
				if (off == N_W'(i)) begin
					ch = cur_q.ext[i];
				end
			end
		end
	end

	assign emit = cur_valid_q && (!out_valid_q || unit_ready);
	assign pop  = q_stat.valid && (!cur_valid_q || (emit && is_last));

	// Serializer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (emit && is_last) begin
				cur_valid_q <= 1'b0;
			end
			if (emit) begin
				pos_q <= is_last ? '0 : pos_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (unit_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the next name and drive the output register
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
			hi_q  <= hi_prod[RECIP_SH +: DIGIT_W];
		end
		if (emit) begin
			code_q <= ch;
			last_q <= is_last;
			nsn_q  <= cur_q.lead_dot;
			nb_q   <= cur_q.lead_dot ? 5'd0 : 5'({n_tot, 1'b0});
		end
	end

	assign unit_valid    = out_valid_q;
	assign code_unit     = {8'h00, code_q};
	assign last_unit     = last_q;
	assign no_short_name = nsn_q;
	assign name_bytes    = nb_q;

endmodule

// File: rtl/short_name_mangler.sv
// Channel | handshake               | payload
// name    | name_valid / name_ready | name_byte, last_byte
// unit    | unit_valid / unit_ready | code_unit, last_unit, no_short_name, name_bytes
//
// The front takes one name byte per cycle while the name queue (two names) has room.
// The back emits one code unit per cycle from a registered output unless unit_ready
// stalls; a name holds the serializer for its n units (n is 1 for a leading dot, else
// base + 4 + extension). A name passes the queue, cur_q and code_q on its way out.
// Reset clears run state, queue pointers and output valid; character stores keep no reset.
// Either side may stall; the queue and the output register keep the other side moving.
module short_name_mangler
	import smn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        name_valid,
	output logic        name_ready,
	input  logic [7:0]  name_byte,
	input  logic        last_byte,
	output logic        unit_valid,
	input  logic        unit_ready,
	output logic [15:0] code_unit,
	output logic        last_unit,
	output logic        no_short_name,
	output logic [4:0]  name_bytes
);

	logic    accept;
	logic    push;
	logic    pop;
	desc_t   push_desc;
	desc_t   head;
	q_stat_t q_stat;

	// Hold input bytes while the queue is full
	assign name_ready = !q_stat.full;
	assign accept     = name_valid && name_ready;

	smn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.name_byte (name_byte),
		.last_byte (last_byte),
		.push      (push),
		.push_desc (push_desc)
	);

	smn_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	smn_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_stat        (q_stat),
		.pop           (pop),
		.unit_valid    (unit_valid),
		.unit_ready    (unit_ready),
		.code_unit     (code_unit),
		.last_unit     (last_unit),
		.no_short_name (no_short_name),
		.name_bytes    (name_bytes)
	);

	// A leading-dot transaction is a single empty unit
	a_lead_single: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && no_short_name |-> last_unit && name_bytes == 5'd0 && code_unit == 16'h0)
		else $error("leading-dot result malformed");

	// A real short name has at least four characters
	a_min_len: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && !no_short_name |-> name_bytes >= 5'd8)
		else $error("short name length too small");

	// A full queue is never empty
	a_q_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> q_stat.valid)
		else $error("queue full flag without entries");

endmodule
